FILE: src/sptpe_pkg.sv
// Package for the SV32 page-table pool engine.
// Holds pool sizing constants, action, status and CSR codes and the memory command type.
package sptpe_pkg;
   localparam int POOL_PAGES = 16;
   localparam int PAGE_W = $clog2(POOL_PAGES);
   localparam int WORD_W = 10;
   localparam int MEM_AW = PAGE_W + WORD_W;

   localparam logic [2:0] ACT_ALLOC = 3'd0;
   localparam logic [2:0] ACT_FREE = 3'd1;
   localparam logic [2:0] ACT_FREE_ALL = 3'd2;
   localparam logic [2:0] ACT_MAP = 3'd3;
   localparam logic [2:0] ACT_UNMAP = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_MEGAPAGE = 2'd2;
   localparam logic [1:0] ST_OUTSIDE = 2'd3;

   localparam logic [1:0] CSR_POOL_BASE = 2'd0;
   localparam logic [1:0] CSR_SHARED_A = 2'd1;
   localparam logic [1:0] CSR_SHARED_B = 2'd2;

   // memory port command from sequencer
   typedef struct packed {
      logic              we;
      logic [MEM_AW-1:0] addr;
      logic [31:0]       wdata;
   } mem_cmd_type;
endpackage

FILE: src/sv32_page_table_pool_engine.sv
// Serves one request at a time; busy stays high through the result cycle.
// Zeroing a page and scanning a root go through the single memory port at one word
// per cycle. The page-used bitmap is scanned one page per cycle.
// Synchronous active-high reset frees every page; results strobe once, no receiver stall.
module sv32_page_table_pool_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_table_addr,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_phys_addr,
   input  logic [9:0]  req_pte_flags,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_addr,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import sptpe_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FIND = 4'd1;
   localparam logic [3:0] S_ZERO = 4'd2;
   localparam logic [3:0] S_SCAN = 4'd3;
   localparam logic [3:0] S_SCAN_W = 4'd4;
   localparam logic [3:0] S_L1_RD = 4'd5;
   localparam logic [3:0] S_L1_W = 4'd6;
   localparam logic [3:0] S_L1_CHK = 4'd7;
   localparam logic [3:0] S_LEAF = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [31:0] base_ff, base_in, sha_ff, sha_in, shb_ff, shb_in;
   logic [POOL_PAGES-1:0] used_ff, used_in;
   logic [2:0] act_ff, act_in;
   logic [31:0] va_ff, va_in, pa_ff, pa_in;
   logic [9:0] flags_ff, flags_in;
   logic [PAGE_W-1:0] rp_ff, rp_in, lp_ff, lp_in, pg_ff, pg_in;
   logic [WORD_W:0] cnt_ff, cnt_in;
   logic [1:0] st_ff, st_in;
   logic [31:0] raddr_ff, raddr_in;
   logic valid_ff, valid_in;
   mem_cmd_type cmd;
   logic [31:0] rdata;

   sptpe_mem u_mem (.clock(clock), .cmd(cmd), .rdata(rdata));

   // pool lookup for an address (shared compare unit)
   logic [32:0] pool_end;
   logic [32:0] chk_addr;
   logic [32:0] off;
   logic        chk_in;
   logic [PAGE_W-1:0] chk_page;
   logic [PAGE_W:0] npages;
   always_comb begin
      pool_end = {1'b0, base_ff} + 33'(POOL_PAGES * 4096);
      if (pool_end > 33'h1_0000_0000) pool_end = 33'h1_0000_0000;
      npages = (PAGE_W+1)'((pool_end - {1'b0, base_ff}) >> 12);
      off = chk_addr - {1'b0, base_ff};
      chk_in = (chk_addr >= {1'b0, base_ff}) && (chk_addr < pool_end);
      chk_page = off[12 +: PAGE_W];
   end

   // PTE target; any PPN bit above 2^32 folds into bit 32, which lies outside every pool
   logic [32:0] pte_tgt;
   assign pte_tgt = {|rdata[31:30], rdata[29:10], 12'd0};
   logic pte_v, pte_rwx;
   assign pte_v = rdata[0];
   assign pte_rwx = |rdata[3:1];

   always_comb begin
      state_in = state_ff; base_in = base_ff; sha_in = sha_ff; shb_in = shb_ff;
      used_in = used_ff; act_in = act_ff; va_in = va_ff; pa_in = pa_ff;
      flags_in = flags_ff; rp_in = rp_ff; lp_in = lp_ff; pg_in = pg_ff;
      cnt_in = cnt_ff; st_in = st_ff; raddr_in = raddr_ff; valid_in = 1'b0;
      cmd = '0; chk_addr = '0;
      case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               case (csr_index)
                  CSR_POOL_BASE: base_in = {csr_wdata[31:12], 12'd0};
                  CSR_SHARED_A: sha_in = csr_wdata;
                  CSR_SHARED_B: shb_in = csr_wdata;
                  default: ;
               endcase
            end
            chk_addr = {1'b0, (req_action == ACT_FREE) ? req_phys_addr : req_table_addr};
            // no request is taken while the result strobe is still up
            if (start && !valid_ff) begin
               act_in = req_action; va_in = req_virt_addr; pa_in = req_phys_addr;
               flags_in = req_pte_flags; rp_in = chk_page; st_in = ST_OK;
               raddr_in = '0; pg_in = '0; cnt_in = '0;
               case (req_action)
                  ACT_ALLOC: state_in = S_FIND;
                  ACT_FREE: begin
                     if (chk_in) used_in[chk_page] = 1'b0;
                     state_in = S_DONE;
                  end
                  ACT_FREE_ALL, ACT_MAP, ACT_UNMAP: begin
                     if (!chk_in) begin
                        st_in = ST_OUTSIDE; state_in = S_DONE;
                     end else if (req_action == ACT_FREE_ALL) state_in = S_SCAN;
                     else state_in = S_L1_RD;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // bitmap search, one page per cycle
         S_FIND: begin
            if ({1'b0, pg_ff} >= npages) begin
               st_in = ST_EXHAUSTED; state_in = S_DONE;
            end else if (!used_ff[pg_ff]) begin
               used_in[pg_ff] = 1'b1; lp_in = pg_ff; cnt_in = '0; state_in = S_ZERO;
            end else if ({1'b0, pg_ff} == (PAGE_W+1)'(POOL_PAGES - 1)) begin
               st_in = ST_EXHAUSTED; state_in = S_DONE;
            end else pg_in = pg_ff + 1'b1;
         end
         // zero the new page, one word per cycle
         S_ZERO: begin
            cmd.we = 1'b1; cmd.addr = {lp_ff, cnt_ff[WORD_W-1:0]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[WORD_W-1:0] == '1) begin
               if (act_ff == ACT_ALLOC) begin
                  raddr_in = base_ff + {{(32-PAGE_W-12){1'b0}}, lp_ff, 12'd0};
                  state_in = S_DONE;
               end else state_in = S_LEAF;
            end
         end
         // root scan: issue reads, check each in the next cycle
         S_SCAN: begin
            cmd.addr = {rp_ff, cnt_ff[WORD_W-1:0]};
            state_in = S_SCAN_W;
         end
         S_SCAN_W: begin
            chk_addr = pte_tgt;
            if (pte_v && !pte_rwx && pte_tgt != {1'b0, sha_ff} && pte_tgt != {1'b0, shb_ff}
                && chk_in)
               used_in[chk_page] = 1'b0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[WORD_W-1:0] == '1) begin
               used_in[rp_ff] = 1'b0; state_in = S_DONE;
            end else begin
               cmd.addr = {rp_ff, cnt_in[WORD_W-1:0]};
            end
         end
         S_L1_RD: begin
            cmd.addr = {rp_ff, va_ff[31:22]};
            state_in = S_L1_W;
         end
         // hold the address so read data stays on the L1 entry
         S_L1_W: begin
            cmd.addr = {rp_ff, va_ff[31:22]};
            state_in = S_L1_CHK;
         end
         S_L1_CHK: begin
            chk_addr = pte_tgt;
            if (!pte_v) begin
               if (act_ff == ACT_MAP) begin
                  pg_in = '0; state_in = S_FIND;
               end else state_in = S_DONE;
            end else if (pte_rwx) begin
               if (act_ff == ACT_MAP) st_in = ST_MEGAPAGE;
               state_in = S_DONE;
            end else if (!chk_in) begin
               st_in = ST_OUTSIDE; state_in = S_DONE;
            end else begin
               lp_in = chk_page; state_in = S_LEAF;
            end
         end
         // write the leaf; after a fresh L0 also the root entry first
         S_LEAF: begin
            if (cnt_ff[WORD_W]) begin
               cmd.we = 1'b1; cmd.addr = {rp_ff, va_ff[31:22]};
               cmd.wdata = {2'b0, (base_ff[31:12] + 20'(lp_ff)), 10'd1};
               cnt_in = '0;
            end else begin
               cmd.we = 1'b1; cmd.addr = {lp_ff, va_ff[21:12]};
               cmd.wdata = (act_ff == ACT_MAP) ? {2'b0, pa_ff[31:12], flags_ff} : 32'd0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; used_ff <= '0; valid_ff <= 1'b0;
         base_ff <= 32'h0010_0000; sha_ff <= '0; shb_ff <= '0;
      end else begin
         state_ff <= state_in; used_ff <= used_in; valid_ff <= valid_in;
         base_ff <= base_in; sha_ff <= sha_in; shb_ff <= shb_in;
      end
      act_ff <= act_in; va_ff <= va_in; pa_ff <= pa_in; flags_ff <= flags_in;
      rp_ff <= rp_in; lp_ff <= lp_in; pg_ff <= pg_in; cnt_ff <= cnt_in;
      st_ff <= st_in; raddr_ff <= raddr_in;
   end

   assign busy = (state_ff != S_IDLE) || valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_status = st_ff;
   assign rsp_result_addr = raddr_ff;
endmodule

FILE: src/sptpe_mem.sv
// Table-word memory: one write/read port, registered read data.
// Depends on sptpe_pkg.
module sptpe_mem (
   input  logic                 clock,
   input  sptpe_pkg::mem_cmd_type cmd,
   output logic [31:0]          rdata
);
   import sptpe_pkg::*;
   logic [31:0] mem [POOL_PAGES*1024];
   logic [31:0] rdata_ff;

   // single port, read-first
   always_ff @(posedge clock) begin
      if (cmd.we) mem[cmd.addr] <= cmd.wdata;
      rdata_ff <= mem[cmd.addr];
   end
   assign rdata = rdata_ff;
endmodule

FILE: src/sptpe_checker.sv
// Port-level checks for the page-table pool engine.
// Depends on sptpe_pkg; bound to sv32_page_table_pool_engine.
module sptpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status
);
   import sptpe_pkg::*;

   // accepted request makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   // strobe lasts a single cycle
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("strobe held");
   // a result is shown while busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   // no result right after acceptance
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid) else $error("early result");
   // status is known whenever a result is shown
   a_status_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_status)) else $error("status unknown");
endmodule

bind sv32_page_table_pool_engine sptpe_checker u_sptpe_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status)
);
